// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers, included by skf_back.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define SKF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is active.
`define SKF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/skf_pkg.sv =====
`timescale 1ns / 1ps

package skf_pkg;

    // Character ring geometry (one slot always stays empty)
    localparam int RING_DEPTH = 256;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    // Decoupling queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Command codes
    localparam logic [1:0] CMD_DECODE = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_INJECT = 2'd2;

    // Scroll request codes
    localparam logic [1:0] SCROLL_NONE = 2'd0;
    localparam logic [1:0] SCROLL_UP   = 2'd1;
    localparam logic [1:0] SCROLL_DOWN = 2'd2;

    // Scan codes of set 1
    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_RSHIFT = 8'h36;
    localparam logic [7:0] SC_CAPS   = 8'h3A;
    localparam logic [7:0] SC_PGUP   = 8'h49;
    localparam logic [7:0] SC_PGDN   = 8'h51;
    localparam logic [7:0] SC_BKSP   = 8'h0E;
    localparam logic [7:0] SC_ENTER  = 8'h1C;
    localparam logic [7:0] SC_LAST   = 8'd57;

    // Control characters produced by the decoder
    localparam logic [7:0] CHAR_BS = 8'h08;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Work handed from front to back
    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_DIRECT
    } op_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] scancode;
        logic [7:0] inject_char;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] read_char;
        logic       read_valid;
        logic       ring_not_empty;
        logic [7:0] direct_char;
        logic       direct_valid;
        logic [1:0] scroll_request;
        logic       key_dropped;
    } res_item_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic [1:0] scroll;
    } q_entry_t;

    // Key map: returns {plain, shifted}; zero marks an unmapped key
    function automatic logic [15:0] key_map(input logic [5:0] code);
        logic [15:0] m;
        case (code)
            6'd2:    m = {"1", "!"};
            6'd3:    m = {"2", "@"};
            6'd4:    m = {"3", "#"};
            6'd5:    m = {"4", "$"};
            6'd6:    m = {"5", "%"};
            6'd7:    m = {"6", "^"};
            6'd8:    m = {"7", "&"};
            6'd9:    m = {"8", "*"};
            6'd10:   m = {"9", "("};
            6'd11:   m = {"0", ")"};
            6'd12:   m = {"-", "_"};
            6'd13:   m = {"=", "+"};
            6'd16:   m = {"q", "Q"};
            6'd17:   m = {"w", "W"};
            6'd18:   m = {"e", "E"};
            6'd19:   m = {"r", "R"};
            6'd20:   m = {"t", "T"};
            6'd21:   m = {"y", "Y"};
            6'd22:   m = {"u", "U"};
            6'd23:   m = {"i", "I"};
            6'd24:   m = {"o", "O"};
            6'd25:   m = {"p", "P"};
            6'd26:   m = {"[", "{"};
            6'd27:   m = {"]", "}"};
            6'd30:   m = {"a", "A"};
            6'd31:   m = {"s", "S"};
            6'd32:   m = {"d", "D"};
            6'd33:   m = {"f", "F"};
            6'd34:   m = {"g", "G"};
            6'd35:   m = {"h", "H"};
            6'd36:   m = {"j", "J"};
            6'd37:   m = {"k", "K"};
            6'd38:   m = {"l", "L"};
            6'd39:   m = {";", ":"};
            6'd40:   m = {8'h27, 8'h22};
            6'd41:   m = {8'h60, 8'h7E};
            6'd43:   m = {8'h5C, 8'h7C};
            6'd44:   m = {"z", "Z"};
            6'd45:   m = {"x", "X"};
            6'd46:   m = {"c", "C"};
            6'd47:   m = {"v", "V"};
            6'd48:   m = {"b", "B"};
            6'd49:   m = {"n", "N"};
            6'd50:   m = {"m", "M"};
            6'd51:   m = {",", "<"};
            6'd52:   m = {".", ">"};
            6'd53:   m = {"/", "?"};
            6'd57:   m = {" ", " "};
            default: m = 16'h0000;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/skf_ram.sv =====
`timescale 1ns / 1ps

module skf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/skf_front.sv =====
`timescale 1ns / 1ps

module skf_front
    import skf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      program_focus_we,
    input  logic      program_focus_wdata,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd_item,
    output logic      q_push,
    output q_entry_t  q_entry,
    input  logic      q_full
);

    logic        focus_reg;
    logic        shift_reg;
    logic        shift_next;
    logic        caps_reg;
    logic        caps_next;
    logic        have_char;
    logic [7:0]  dec_char;
    logic [15:0] map_pair;
    logic        is_letter;
    logic        upper;
    logic [7:0]  sc;

    assign sc        = cmd_item.scancode;
    assign cmd_stall = q_full;
    assign q_push    = cmd_valid && !q_full;

    // Key map lookup and case selection
    assign map_pair  = key_map(sc[5:0]);
    assign is_letter = (map_pair[15:8] >= "a") && (map_pair[15:8] <= "z");
    assign upper     = is_letter ? (shift_reg ^ caps_reg) : shift_reg;

    // Classify the item and work out modifier updates
    always_comb
    begin
        shift_next     = shift_reg;
        caps_next      = caps_reg;
        have_char      = 1'b0;
        dec_char       = 8'h00;
        q_entry.op     = OP_NONE;
        q_entry.ch     = 8'h00;
        q_entry.scroll = SCROLL_NONE;
        unique case (cmd_item.cmd)
            CMD_DECODE:
            begin
                if (sc[7])
                begin
                    // release: only a Shift release matters
                    if ({1'b0, sc[6:0]} == SC_LSHIFT || {1'b0, sc[6:0]} == SC_RSHIFT)
                    begin
                        shift_next = 1'b0;
                    end
                end
                else if (sc == SC_LSHIFT || sc == SC_RSHIFT)
                begin
                    shift_next = 1'b1;
                end
                else if (sc == SC_CAPS)
                begin
                    caps_next = !caps_reg;
                end
                else if (sc == SC_PGUP)
                begin
                    q_entry.scroll = SCROLL_UP;
                end
                else if (sc == SC_PGDN)
                begin
                    q_entry.scroll = SCROLL_DOWN;
                end
                else if (sc == SC_BKSP)
                begin
                    have_char = 1'b1;
                    dec_char  = CHAR_BS;
                end
                else if (sc == SC_ENTER)
                begin
                    have_char = 1'b1;
                    dec_char  = CHAR_LF;
                end
                else if (sc <= SC_LAST && map_pair[15:8] != 8'h00)
                begin
                    have_char = 1'b1;
                    dec_char  = upper ? map_pair[7:0] : map_pair[15:8];
                end
                if (have_char)
                begin
                    q_entry.op = focus_reg ? OP_PUSH : OP_DIRECT;
                    q_entry.ch = dec_char;
                end
            end
            CMD_READ:
            begin
                q_entry.op = OP_POP;
            end
            CMD_INJECT:
            begin
                q_entry.op = OP_PUSH;
                q_entry.ch = cmd_item.inject_char;
            end
            default:
            begin
                q_entry.op = OP_NONE;
            end
        endcase
    end

    // Focus register and modifier state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_reg <= 1'b0;
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
        end
        else
        begin
            if (program_focus_we)
            begin
                focus_reg <= program_focus_wdata;
            end
            if (q_push)
            begin
                shift_reg <= shift_next;
                caps_reg  <= caps_next;
            end
        end
    end

endmodule

// ===== hw/rtl/skf_queue.sv =====
`timescale 1ns / 1ps

module skf_queue
    import skf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output q_entry_t head_entry
);

    q_entry_t          entries [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_next;
    logic [Q_CW-1:0]   count_reg;
    logic [Q_CW-1:0]   count_next;

    assign full       = (count_reg == Q_CW'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entries[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + Q_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + Q_AW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + Q_CW'(1);
            2'b01:   count_next = count_reg - Q_CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/skf_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skf_back
    import skf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  q_entry_t  q_entry,
    output logic      q_pop,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item
);

    logic [RING_AW-1:0] wr_idx_reg;
    logic [RING_AW-1:0] wr_idx_next;
    logic [RING_AW-1:0] rd_idx_reg;
    logic [RING_AW-1:0] rd_idx_next;
    logic [RING_AW-1:0] wr_inc;
    logic [RING_AW-1:0] rd_inc;
    logic               ring_full;
    logic               ring_empty;
    logic               advance;
    logic               do_write;
    logic               do_read;
    logic               out_valid_reg;
    logic               out_valid_next;
    res_item_t          out_reg;
    res_item_t          out_next;
    logic [7:0]         ram_rdata;

    // Take the next item when the output slot is free or being emptied
    assign advance = q_valid && (!out_valid_reg || !res_stall);
    assign q_pop   = advance;

    // Ring index arithmetic
    assign wr_inc     = (wr_idx_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : wr_idx_reg + RING_AW'(1);
    assign rd_inc     = (rd_idx_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : rd_idx_reg + RING_AW'(1);
    assign ring_full  = (wr_inc == rd_idx_reg);
    assign ring_empty = (rd_idx_reg == wr_idx_reg);
    assign do_write   = advance && (q_entry.op == OP_PUSH) && !ring_full;
    assign do_read    = advance && (q_entry.op == OP_POP) && !ring_empty;

    assign wr_idx_next = do_write ? wr_inc : wr_idx_reg;
    assign rd_idx_next = do_read ? rd_inc : rd_idx_reg;

    // Result fields; the popped character arrives from the RAM read register
    always_comb
    begin
        out_next.read_char      = 8'h00;
        out_next.read_valid     = do_read;
        out_next.ring_not_empty = (wr_idx_next != rd_idx_next);
        out_next.direct_valid   = (q_entry.op == OP_DIRECT);
        out_next.direct_char    = (q_entry.op == OP_DIRECT) ? q_entry.ch : 8'h00;
        out_next.scroll_request = q_entry.scroll;
        out_next.key_dropped    = (q_entry.op == OP_PUSH) && ring_full;
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    skf_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (do_write),
        .waddr (wr_idx_reg),
        .wdata (q_entry.ch),
        .re    (do_read),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        res_item = out_reg;
        if (out_reg.read_valid)
        begin
            res_item.read_char = ram_rdata;
        end
    end

    assign res_valid = out_valid_reg;

    // A result never carries both a popped and a direct character
    `SKF_ASSERT_IMP(a_read_direct_excl, clk, rst_n, out_valid_reg,
        !(out_reg.read_valid && out_reg.direct_valid))
    // A pop moves the read index
    `SKF_ASSERT_NEXT(a_pop_moves_rd, clk, rst_n, do_read, rd_idx_reg != $past(rd_idx_reg))
    // A push into a full ring leaves the write index and flags the drop
    `SKF_ASSERT_NEXT(a_drop_holds_wr, clk, rst_n,
        advance && ring_full && (q_entry.op == OP_PUSH),
        $stable(wr_idx_reg) && out_reg.key_dropped)

endmodule

// ===== hw/rtl/scancode_to_ascii_key_fifo_unit.sv =====
`timescale 1ns / 1ps
// Scan-code-set-1 keyboard decoder with a 256-entry character ring.
// Command channel: cmd_valid / cmd_stall / cmd_item (decode, read, inject).
// Result channel:  res_valid / res_stall / res_item, exactly one result per item,
// in order. program_focus_we / program_focus_wdata select ring (1) or
// direct output (0); write it only while the block is idle.
// An accepted item is written into the queue, then moved from the queue head
// into the output register when the output is free, so its result waits
// longer while the receiver stalls.
// Throughput: one item per cycle while res_stall is low, set by the registered
// ring update and the one RAM write and one registered RAM read per cycle.
// A two-entry queue separates decode from ring execution; when res_stall is
// held, the output register and queue fill and cmd_stall rises once the
// queue is full. Results stay stable while stalled.
// Reset clears Shift, Caps Lock, focus and the ring indices; ring contents
// are not cleared and need no clearing pass.

module scancode_to_ascii_key_fifo_unit
    import skf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      program_focus_we,
    input  logic      program_focus_wdata,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd_item,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_item
);

    logic     q_push;
    q_entry_t q_in;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_head;

    // Decode and classify
    skf_front u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .program_focus_we    (program_focus_we),
        .program_focus_wdata (program_focus_wdata),
        .cmd_valid           (cmd_valid),
        .cmd_stall           (cmd_stall),
        .cmd_item            (cmd_item),
        .q_push              (q_push),
        .q_entry             (q_in),
        .q_full              (q_full)
    );

    // Decoupling queue
    skf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head)
    );

    // Ring execution and result register
    skf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule
